/* design/assert_macros.svh */
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// checked only while out of reset
`define ASSERT_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// checked at every rising edge
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`else

`define ASSERT_RST(lbl, clk, rst, prop)
`define ASSERT_ALWAYS(lbl, clk, prop)

`endif

`endif

/* design/me_pkg.sv */
`default_nettype none

package me_pkg;

  localparam int BLOCK_LEN_DEF = 32;

  localparam logic [15:0] THRESHOLD_RESET = 16'd80;
  localparam logic [19:0] ENERGY_MAX      = 20'hFFFFF;
  localparam logic [18:0] AXIS_MAX        = 19'h7FFFF;

  typedef struct packed {
    logic signed [15:0] sample_x;
    logic signed [15:0] sample_y;
    logic signed [15:0] sample_z;
  } in_item_t;

  typedef struct packed {
    logic [19:0] energy;
    logic [18:0] energy_x;
    logic [18:0] energy_y;
    logic [18:0] energy_z;
    logic        moving;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT_START,
    ST_ROOT_WAIT,
    ST_EMIT
  } state_t;

  // per-sample sequence: square x, y, z, then fold in the last product
  typedef enum logic [1:0] {
    STEP_X,
    STEP_Y,
    STEP_Z,
    STEP_LAST
  } step_t;

  typedef enum logic [1:0] {
    ROOT_TOTAL,
    ROOT_X,
    ROOT_Y,
    ROOT_Z
  } root_sel_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

`default_nettype wire

/* design/me_sqrt.sv */
`default_nettype none

module me_sqrt import me_pkg::*; #(
  parameter int ROOT_W = 20
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [2*ROOT_W-1:0]   radicand,
  output logic      [ROOT_W-1:0]     root,
  output sqrt_stat_t                 stat
);

`include "assert_macros.svh"

  localparam int REM_W = ROOT_W + 2;
  localparam int CNT_W = (ROOT_W > 1) ? $clog2(ROOT_W) : 1;

  logic [2*ROOT_W-1:0] rad;
  logic [REM_W-1:0]    rem;
  logic [ROOT_W-1:0]   root_acc;
  logic [CNT_W-1:0]    cnt;
  logic                busy;
  logic                done;

  logic [REM_W-1:0]    rem_sh;
  logic [REM_W-1:0]    trial;
  logic                fit;
  logic [REM_W-1:0]    rem_next;
  logic [ROOT_W-1:0]   root_next;
  logic                load;

  // one result bit per cycle, restoring digit recurrence
  always_comb begin
    rem_sh    = {rem[ROOT_W-1:0], rad[2*ROOT_W-1 -: 2]};
    trial     = {root_acc, 2'b01};
    fit       = (rem_sh >= trial);
    rem_next  = fit ? (rem_sh - trial) : rem_sh;
    root_next = {root_acc[ROOT_W-2:0], fit};
  end

  assign load = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (load) begin
        busy <= 1'b1;
      end else if (busy && (cnt == '0)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rad      <= radicand;
      rem      <= '0;
      root_acc <= '0;
      cnt      <= CNT_W'(ROOT_W - 1);
    end else if (busy) begin
      rad      <= rad << 2;
      rem      <= rem_next;
      root_acc <= root_next;
      cnt      <= cnt - 1'b1;
    end
  end

  assign root = root_acc;
  assign stat = '{busy: busy, done: done};

  `ASSERT_RST(a_start_busy, clk, rst, load |=> busy)
  `ASSERT_RST(a_done_from_busy, clk, rst, done |-> $past(busy))
  `ASSERT_RST(a_done_idle, clk, rst, done |-> !busy)

endmodule

`default_nettype wire

/* design/accel_block_motion_energy.sv */
// channel   direction   transfer when          payload
// in        into block  in_valid & !in_stall   in_item_t: sample_x/y/z
// out       from block  out_valid & !out_stall out_item_t: energy, axis roots, moving
// cfg       into block  cfg_wen                movement_threshold
//
// each sample: the accept, then 4 steps of the shared 16x16 squarer and adder
// the last sample of a block adds 4 roots on one shared unit, one after another,
// then ST_EMIT loads the output register once it is free
// synchronous reset clears the sums and the previous sample and sets the threshold to 80
// a held result does not block new samples; only the next block end waits on out_stall
`default_nettype none

module accel_block_motion_energy import me_pkg::*; #(
  parameter int BLOCK_LEN = BLOCK_LEN_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_item_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_item_t        out_data,
  input  wire logic        cfg_wen,
  input  wire logic [15:0] cfg_wdata
);

`include "assert_macros.svh"

  localparam int AXIS_W  = 32 + $clog2(BLOCK_LEN);
  localparam int TOTAL_W = AXIS_W + 2;
  localparam int ROOT_W  = (TOTAL_W + 1) / 2;
  localparam int RAD_W   = 2 * ROOT_W;
  localparam int CMP_W   = (ROOT_W > 20) ? ROOT_W : 20;
  localparam int CNT_W   = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;

  state_t            state, state_next;
  step_t             step;
  root_sel_t         root_sel;
  logic [CNT_W-1:0]  block_index;
  logic              have_prev;
  logic [15:0]       threshold;

  logic signed [15:0] samp_x, samp_y, samp_z;
  logic signed [15:0] prev_x, prev_y, prev_z;
  logic [31:0]        prod;
  logic [AXIS_W-1:0]  sum_x, sum_y, sum_z;
  logic [TOTAL_W-1:0] sum_total;

  logic [19:0] res_energy;
  logic [18:0] res_x, res_y, res_z;

  logic              accept;
  logic              out_free;
  logic              sq_start;
  logic [RAD_W-1:0]  sq_radicand;
  logic [ROOT_W-1:0] sq_root;
  sqrt_stat_t        sq_stat;

  logic signed [15:0] mul_a, mul_b;
  logic signed [16:0] diff;
  logic [15:0]        mag;
  logic [CMP_W-1:0]   root_wide;
  logic [19:0]        root_e;
  logic [18:0]        root_a;

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    sq_start   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_SQ;
      end
      ST_SQ: begin
        if (step == STEP_LAST) begin
          if (block_index == CNT_W'(BLOCK_LEN - 1)) state_next = ST_ROOT_START;
          else state_next = ST_IDLE;
        end
      end
      ST_ROOT_START: begin
        sq_start   = 1'b1;
        state_next = ST_ROOT_WAIT;
      end
      ST_ROOT_WAIT: begin
        if (sq_stat.done) begin
          if (root_sel == ROOT_Z) state_next = ST_EMIT;
          else state_next = ST_ROOT_START;
        end
      end
      ST_EMIT: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // squarer operand: magnitude of the difference on the current axis
  always_comb begin
    case (step)
      STEP_X:  begin mul_a = samp_x; mul_b = prev_x; end
      STEP_Y:  begin mul_a = samp_y; mul_b = prev_y; end
      default: begin mul_a = samp_z; mul_b = prev_z; end
    endcase
    diff = 17'(mul_a) - 17'(mul_b);
    mag  = diff[16] ? 16'(-diff) : diff[15:0];
  end

  always_comb begin
    case (root_sel)
      ROOT_TOTAL: sq_radicand = RAD_W'(sum_total);
      ROOT_X:     sq_radicand = RAD_W'(sum_x);
      ROOT_Y:     sq_radicand = RAD_W'(sum_y);
      default:    sq_radicand = RAD_W'(sum_z);
    endcase
    root_wide = CMP_W'(sq_root);
    root_e    = (root_wide > CMP_W'(ENERGY_MAX)) ? ENERGY_MAX : root_wide[19:0];
    root_a    = (root_wide > CMP_W'(AXIS_MAX)) ? AXIS_MAX : root_wide[18:0];
  end

  me_sqrt #(
    .ROOT_W (ROOT_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (sq_start),
    .radicand (sq_radicand),
    .root     (sq_root),
    .stat     (sq_stat)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      step        <= STEP_X;
      root_sel    <= ROOT_TOTAL;
      block_index <= '0;
      have_prev   <= 1'b0;
      threshold   <= THRESHOLD_RESET;
      out_valid   <= 1'b0;
      prev_x      <= '0;
      prev_y      <= '0;
      prev_z      <= '0;
      sum_x       <= '0;
      sum_y       <= '0;
      sum_z       <= '0;
      sum_total   <= '0;
    end else begin
      if (cfg_wen) threshold <= cfg_wdata;

      if (accept) begin
        step <= STEP_X;
        if (!have_prev) begin
          // first sample stands in as its own predecessor
          prev_x    <= in_data.sample_x;
          prev_y    <= in_data.sample_y;
          prev_z    <= in_data.sample_z;
          have_prev <= 1'b1;
        end
      end

      if (state == ST_SQ) begin
        step <= step_t'(step + 1'b1);
        case (step)
          STEP_Y:  sum_x <= sum_x + AXIS_W'(prod);
          STEP_Z:  sum_y <= sum_y + AXIS_W'(prod);
          STEP_LAST: sum_z <= sum_z + AXIS_W'(prod);
          default: ;
        endcase
        if (step != STEP_X) sum_total <= sum_total + TOTAL_W'(prod);
        if (step == STEP_LAST) begin
          prev_x <= samp_x;
          prev_y <= samp_y;
          prev_z <= samp_z;
          if (block_index == CNT_W'(BLOCK_LEN - 1)) begin
            block_index <= '0;
            root_sel    <= ROOT_TOTAL;
          end else begin
            block_index <= block_index + 1'b1;
          end
        end
      end

      if (state == ST_ROOT_WAIT && sq_stat.done && root_sel != ROOT_Z) begin
        root_sel <= root_sel_t'(root_sel + 1'b1);
      end

      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
        sum_x     <= '0;
        sum_y     <= '0;
        sum_z     <= '0;
        sum_total <= '0;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      samp_x <= in_data.sample_x;
      samp_y <= in_data.sample_y;
      samp_z <= in_data.sample_z;
    end
    if (state == ST_SQ && step != STEP_LAST) prod <= mag * mag;
    if (state == ST_ROOT_WAIT && sq_stat.done) begin
      case (root_sel)
        ROOT_TOTAL: res_energy <= root_e;
        ROOT_X:     res_x      <= root_a;
        ROOT_Y:     res_y      <= root_a;
        default:    res_z      <= root_a;
      endcase
    end
    if (state == ST_EMIT && out_free) begin
      out_data.energy   <= res_energy;
      out_data.energy_x <= res_x;
      out_data.energy_y <= res_y;
      out_data.energy_z <= res_z;
      out_data.moving   <= (res_energy > 20'(threshold));
    end
  end

  `ASSERT_RST(a_start_free, clk, rst, sq_start |-> !sq_stat.busy)
  `ASSERT_RST(a_accept_busy, clk, rst, accept |=> in_stall)
  `ASSERT_RST(a_total_split, clk, rst,
    (state == ST_IDLE) |-> (sum_total == TOTAL_W'(sum_x) + TOTAL_W'(sum_y) + TOTAL_W'(sum_z)))
  `ASSERT_RST(a_block_clear, clk, rst,
    (state == ST_IDLE && block_index == '0) |-> (sum_total == '0))

endmodule

`default_nettype wire

/* verif/testbench.sv */
`default_nettype none

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import me_pkg::*;

  localparam int BLOCK = BLOCK_LEN_DEF;
  localparam int SETTLE_CYCLES = 150;
  localparam int TIMEOUT_NS = 5_000_000;
  localparam logic [15:0] CALIBRATED_LIMIT = 16'd80;
  localparam logic [15:0] UNCALIBRATED_LIMIT = 16'd750;

  typedef enum {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_HOLD} stall_mode_t;
  typedef enum {RUN_WALK, RUN_WIDE, RUN_EXTREME, RUN_STILL} run_style_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_wen = 1'b0;
  logic [15:0] cfg_wdata = '0;

  accel_block_motion_energy #(.BLOCK_LEN(BLOCK)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wen(cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // samples waiting to be driven and block results waiting to come out
  in_item_t sample_backlog[$];
  out_item_t block_energies[$];

  int samples_queued = 0;
  int samples_taken = 0;
  int blocks_checked = 0;
  int moving_blocks = 0;
  int limits_written = 0;
  int errors = 0;

  // predictor state
  logic [15:0] move_limit = THRESHOLD_RESET;
  logic signed [15:0] last_x, last_y, last_z;
  logic primed;
  int in_block;
  logic [63:0] sq_sum_x, sq_sum_y, sq_sum_z, sq_total;

  // last generated sample, so random walks continue smoothly
  int gen_x = 0;
  int gen_y = 0;
  int gen_z = 0;
  int walk_steps[8] = '{1, 3, 8, 16, 40, 90, 300, 2000};

  function automatic logic [63:0] floor_root(logic [63:0] v);
    logic [63:0] r;
    logic [63:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [63:0] capped_root(logic [63:0] v, logic [63:0] cap);
    logic [63:0] r;
    r = floor_root(v);
    return (r > cap) ? cap : r;
  endfunction

  function automatic int clamp16(int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic int pick_extreme();
    case ($urandom_range(0, 4))
      0: return -32768;
      1: return 32767;
      2: return 0;
      3: return -1;
      default: return 1;
    endcase
  endfunction

  task automatic accumulate_sample(in_item_t s);
    longint dx, dy, dz;
    out_item_t blk;
    if (!primed) begin
      // first sample after reset is its own previous sample
      last_x = s.sample_x;
      last_y = s.sample_y;
      last_z = s.sample_z;
      primed = 1'b1;
    end
    dx = longint'(s.sample_x) - longint'(last_x);
    dy = longint'(s.sample_y) - longint'(last_y);
    dz = longint'(s.sample_z) - longint'(last_z);
    sq_sum_x += 64'(dx * dx);
    sq_sum_y += 64'(dy * dy);
    sq_sum_z += 64'(dz * dz);
    sq_total += 64'(dx * dx + dy * dy + dz * dz);
    last_x = s.sample_x;
    last_y = s.sample_y;
    last_z = s.sample_z;
    in_block++;
    if (in_block == BLOCK) begin
      blk.energy = 20'(capped_root(sq_total, 64'(ENERGY_MAX)));
      blk.energy_x = 19'(capped_root(sq_sum_x, 64'(AXIS_MAX)));
      blk.energy_y = 19'(capped_root(sq_sum_y, 64'(AXIS_MAX)));
      blk.energy_z = 19'(capped_root(sq_sum_z, 64'(AXIS_MAX)));
      blk.moving = (blk.energy > 20'(move_limit));
      block_energies.push_back(blk);
      in_block = 0;
      sq_sum_x = '0;
      sq_sum_y = '0;
      sq_sum_z = '0;
      sq_total = '0;
    end
  endtask

  // input and output monitor, sampled at the rising edge
  logic in_fire = 1'b0;

  always @(posedge clk) begin : watch
    out_item_t want;
    if (rst) begin
      in_fire <= 1'b0;
      primed = 1'b0;
      in_block = 0;
      last_x = '0;
      last_y = '0;
      last_z = '0;
      sq_sum_x = '0;
      sq_sum_y = '0;
      sq_sum_z = '0;
      sq_total = '0;
    end else begin
      in_fire <= in_valid && !in_stall;
      if (in_valid && !in_stall) begin
        accumulate_sample(in_data);
        samples_taken++;
      end
      if (out_valid && !out_stall) begin
        if (block_energies.size() == 0) begin
          errors++;
          $error("result transfer with no block pending: energy %0d", out_data.energy);
        end else begin
          want = block_energies.pop_front();
          if (out_data.energy !== want.energy) begin
            errors++;
            $error("energy: expected %0d, got %0d", want.energy, out_data.energy);
          end
          if (out_data.energy_x !== want.energy_x) begin
            errors++;
            $error("energy_x: expected %0d, got %0d", want.energy_x, out_data.energy_x);
          end
          if (out_data.energy_y !== want.energy_y) begin
            errors++;
            $error("energy_y: expected %0d, got %0d", want.energy_y, out_data.energy_y);
          end
          if (out_data.energy_z !== want.energy_z) begin
            errors++;
            $error("energy_z: expected %0d, got %0d", want.energy_z, out_data.energy_z);
          end
          if (out_data.moving !== want.moving) begin
            errors++;
            $error("moving: expected %0d, got %0d", want.moving, out_data.moving);
          end
          blocks_checked++;
          if (want.moving) moving_blocks++;
        end
      end
    end
  end

  // sample driver: bursts with random gaps
  int burst_left = 8;
  int gap_left = 0;

  always @(negedge clk) begin : drive
    logic next_valid;
    in_item_t next_item;
    next_valid = in_valid;
    next_item = in_data;
    if (rst) begin
      next_valid = 1'b0;
    end else if (!in_valid || in_fire) begin
      next_valid = 1'b0;
      if (gap_left > 0) begin
        gap_left--;
      end else if (sample_backlog.size() > 0) begin
        next_valid = 1'b1;
        next_item = sample_backlog.pop_front();
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 60);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
    in_valid <= next_valid;
    in_data <= next_item;
  end

  // result stall pattern
  stall_mode_t stall_mode = STALL_NONE;
  int stall_run = 0;

  always @(negedge clk) begin
    if (stall_run == 0) begin
      case ($urandom_range(0, 3))
        0: stall_mode = STALL_NONE;
        1: stall_mode = STALL_LIGHT;
        2: stall_mode = STALL_HEAVY;
        default: stall_mode = STALL_HOLD;
      endcase
      stall_run = (stall_mode == STALL_HOLD) ? $urandom_range(10, 150) : $urandom_range(20, 300);
    end
    stall_run--;
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 7) != 0);
      default: out_stall <= 1'b1;
    endcase
  end

  task automatic push_sample(int x, int y, int z);
    in_item_t s;
    gen_x = x;
    gen_y = y;
    gen_z = z;
    s.sample_x = 16'(x);
    s.sample_y = 16'(y);
    s.sample_z = 16'(z);
    sample_backlog.push_back(s);
    samples_queued++;
  endtask

  task automatic queue_random(int count);
    run_style_t style;
    int run_left;
    int step;
    style = RUN_WALK;
    run_left = 0;
    step = 1;
    for (int k = 0; k < count; k++) begin
      if (run_left == 0) begin
        run_left = $urandom_range(1, 40);
        case ($urandom_range(0, 9))
          0, 1: style = RUN_WIDE;
          2: style = RUN_EXTREME;
          3: style = RUN_STILL;
          default: style = RUN_WALK;
        endcase
        step = walk_steps[$urandom_range(0, 7)];
      end
      run_left--;
      case (style)
        RUN_WIDE: push_sample(int'($urandom_range(0, 65535)) - 32768,
                              int'($urandom_range(0, 65535)) - 32768,
                              int'($urandom_range(0, 65535)) - 32768);
        RUN_EXTREME: push_sample(pick_extreme(), pick_extreme(), pick_extreme());
        RUN_STILL: push_sample(gen_x, gen_y, gen_z);
        default: push_sample(clamp16(gen_x + int'($urandom_range(0, 2 * step)) - step),
                             clamp16(gen_y + int'($urandom_range(0, 2 * step)) - step),
                             clamp16(gen_z + int'($urandom_range(0, 2 * step)) - step));
      endcase
    end
  endtask

  // sender holds off until every sample is taken and every block result is out
  task automatic wait_drained();
    while (samples_taken != samples_queued || block_energies.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_threshold(logic [15:0] v);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    move_limit = v;
    limits_written++;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // reset threshold; first sample sees no difference, then full-scale swings
    push_sample(32767, -32768, 0);
    push_sample(-32768, 32767, 0);
    push_sample(32767, -32768, -32768);
    push_sample(-32768, 32767, 32767);
    push_sample(-32768, 32767, 32767);
    push_sample(0, 0, 0);
    push_sample(-1, 1, -1);
    push_sample(1, -1, 1);
    push_sample(21845, -21846, 21845);
    push_sample(-21846, 21845, -21846);
    push_sample(32767, 32767, 32767);
    push_sample(-32768, -32768, -32768);
    push_sample(32767, 32767, 32767);
    push_sample(0, 0, 0);
    push_sample(-32768, 0, 32767);
    push_sample(32767, -1, -32768);
    push_sample(100, -100, 50);
    push_sample(100, -100, 50);
    push_sample(-1, -1, -1);
    push_sample(0, 0, 0);
    queue_random(260);

    for (int p = 0; p < 7; p++) begin
      wait_drained();
      case (p)
        0: set_threshold(16'd0);
        1: set_threshold(16'hFFFF);
        2: set_threshold(UNCALIBRATED_LIMIT);
        3: set_threshold(CALIBRATED_LIMIT);
        4: set_threshold(16'($urandom_range(0, 65535)));
        5: set_threshold(16'd1);
        default: set_threshold(16'($urandom_range(100, 2000)));
      endcase
      queue_random($urandom_range(200, 300));
    end
    wait_drained();

    $display("covered %0d samples in %0d checked blocks (%0d moving, %0d still)",
             samples_taken, blocks_checked, moving_blocks, blocks_checked - moving_blocks);
    $display("threshold rewritten %0d times, including both ends of its range",
             limits_written);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout: %0d samples taken of %0d, %0d block results outstanding",
             samples_taken, samples_queued, block_energies.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire
